@@ rtl/core/tcfa_pkg.sv @@
// ----------------------------------------------------------------------------
// tcfa_pkg
// Shared constants and types for the tile-coding feature allocator.
// ----------------------------------------------------------------------------
package tcfa_pkg;

    localparam int MAX_TILINGS_DEF   = 8;
    localparam int MAX_DIMS_DEF      = 16;
    localparam int TABLE_ENTRIES_DEF = 256;

    localparam logic [11:0] ID_LIMIT = 12'd2048;
    localparam logic [3:0]  ACT_RST  = 4'd8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // word handed from the front to the back through the queue
    typedef struct packed {
        logic        cmd;
        logic [2:0]  tiling_index;
        logic [3:0]  dim_index;
        logic        dim_enabled;
        logic [31:0] offset_value;
        logic [31:0] inverse_width;
        logic [31:0] sample_value;
        logic        last_element;
    } t_word;

endpackage

@@ rtl/core/tcfa_ram.sv @@
// ----------------------------------------------------------------------------
// tcfa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tcfa_queue.sv @@
// ----------------------------------------------------------------------------
// tcfa_queue
// Front part: takes command words and holds them in a short queue.
// ----------------------------------------------------------------------------
module tcfa_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcfa_pkg::t_word i_word,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output tcfa_pkg::t_word o_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tcfa_pkg::t_word r_buf [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_buf[r_rp];

    // pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_word;
        end
    end

endmodule

@@ rtl/core/tcfa_engine.sv @@
// ----------------------------------------------------------------------------
// tcfa_engine
// Back part: parameter loads, per-tiling quantise and hash through one
// shared multiplier, and the table walk that assigns feature ids.
// ----------------------------------------------------------------------------
module tcfa_engine #(
    parameter int MAX_TILINGS   = tcfa_pkg::MAX_TILINGS_DEF,
    parameter int MAX_DIMS      = tcfa_pkg::MAX_DIMS_DEF,
    parameter int TABLE_ENTRIES = tcfa_pkg::TABLE_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [3:0]      i_active,
    input  logic            i_empty,
    input  tcfa_pkg::t_word i_word,
    output logic            o_pop,
    output logic            o_idle,
    output logic            o_valid,
    output logic [2:0]      o_tiling_number,
    output logic [10:0]     o_feature_id,
    output logic            o_newly_created,
    output logic            o_table_full,
    output logic [11:0]     o_feature_count,
    output logic            o_last_result
);

    localparam int TW  = (MAX_TILINGS > 1) ? $clog2(MAX_TILINGS) : 1;
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PD  = MAX_TILINGS * MAX_DIMS;
    localparam int PW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int EW  = $clog2(TABLE_ENTRIES);
    localparam int SD  = MAX_TILINGS * TABLE_ENTRIES;
    localparam int SW  = $clog2(SD);
    localparam int FW  = EW + 1;
    localparam int PSW = DW + 1;

    // states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRD   = 4'd1;
    localparam logic [3:0] S_PMUL  = 4'd2;
    localparam logic [3:0] S_PSAT  = 4'd3;
    localparam logic [3:0] S_LSET  = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LCMP  = 4'd6;
    localparam logic [3:0] S_LEMIT = 4'd7;
    localparam logic [3:0] S_PWAIT = 4'd8;
    localparam logic [3:0] S_PMUL2 = 4'd9;

    logic [3:0]       r_state, n_state;
    tcfa_pkg::t_word  r_w;
    logic [TW-1:0]    r_t;
    logic [TW-1:0]    r_n_last;
    logic [PSW-1:0]   r_pos;
    logic [31:0]      r_hash [MAX_TILINGS];
    logic [FW-1:0]    r_fill [MAX_TILINGS];
    logic [11:0]      r_next;
    logic [EW:0]      r_i;
    logic [31:0]      r_mag;
    logic             r_neg;
    logic [63:0]      r_prod;
    logic [47:0]      r_phi;
    logic [31:0]      r_inv;
    logic             r_ena;

    // parameter memories
    logic        pm_we;
    logic [PW-1:0] pm_waddr, pm_raddr;
    logic [31:0] off_rd, inv_rd;
    logic        en_rd;

    assign pm_we    = (r_state == S_IDLE) && !i_empty && (i_word.cmd == tcfa_pkg::CMD_LOAD)
                      && (32'(i_word.tiling_index) < 32'(MAX_TILINGS))
                      && (32'(i_word.dim_index) < 32'(MAX_DIMS));
    assign pm_waddr = PW'(32'(i_word.tiling_index) * MAX_DIMS + 32'(i_word.dim_index));
    assign pm_raddr = PW'(32'(r_t) * MAX_DIMS + 32'(r_pos));

    tcfa_ram #(.WIDTH(32), .DEPTH(PD)) u_off (
        .i_clk, .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(i_word.offset_value),
        .i_raddr(pm_raddr), .o_rdata(off_rd));
    tcfa_ram #(.WIDTH(32), .DEPTH(PD)) u_inv (
        .i_clk, .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(i_word.inverse_width),
        .i_raddr(pm_raddr), .o_rdata(inv_rd));
    tcfa_ram #(.WIDTH(1), .DEPTH(PD)) u_en (
        .i_clk, .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(i_word.dim_enabled),
        .i_raddr(pm_raddr), .o_rdata(en_rd));

    // seen tables: hash and id
    logic          st_we;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [31:0]   sh_rd;
    logic [10:0]   sf_rd;
    logic          miss_ok;

    assign st_raddr = SW'(32'(r_t) * TABLE_ENTRIES + 32'(r_i[EW-1:0]));
    assign st_waddr = SW'(32'(r_t) * TABLE_ENTRIES + 32'(r_fill[r_t][EW-1:0]));
    assign miss_ok  = (32'(r_fill[r_t]) < 32'(TABLE_ENTRIES)) && (r_next < tcfa_pkg::ID_LIMIT);

    tcfa_ram #(.WIDTH(32), .DEPTH(SD)) u_sh (
        .i_clk, .i_we(st_we), .i_waddr(st_waddr), .i_wdata(r_hash[r_t]),
        .i_raddr(st_raddr), .o_rdata(sh_rd));
    tcfa_ram #(.WIDTH(11), .DEPTH(SD)) u_sf (
        .i_clk, .i_we(st_we), .i_waddr(st_waddr), .i_wdata(r_next[10:0]),
        .i_raddr(st_raddr), .o_rdata(sf_rd));

    // datapath helpers
    logic [32:0] diff;
    logic [31:0] dmag;
    logic [15:0] mop;
    logic [47:0] mpart;
    logic [32:0] q;
    logic [31:0] coord;
    logic        hit, scan_end;

    assign diff = {r_w.sample_value[31], r_w.sample_value} - {off_rd[31], off_rd};
    // difference of two 32-bit signed values has a magnitude below 2^32
    assign dmag = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
    // one 16x32 multiplier: low half of the magnitude, then the high half
    assign mop   = (r_state == S_PMUL) ? r_mag[15:0] : r_mag[31:16];
    assign mpart = {32'd0, mop} * {16'd0, r_inv};
    assign q    = {1'b0, r_prod[63:32]} + 33'(r_neg && (r_prod[31:0] != 32'd0));
    always_comb begin
        if (!r_neg) begin
            coord = (q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end else begin
            coord = (q > 33'h080000000) ? 32'h80000000 : (32'd0 - q[31:0]);
        end
    end
    assign hit      = (sh_rd == r_hash[r_t]);
    assign scan_end = (32'(r_i) >= 32'(r_fill[r_t])) || (32'(r_i) >= 32'(TABLE_ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && i_word.cmd == tcfa_pkg::CMD_SAMPLE) begin
                    n_state = (32'(r_pos) < 32'(MAX_DIMS)) ? S_PRD :
                              (i_word.last_element ? S_LSET : S_IDLE);
                end
            end
            S_PRD:   n_state = S_PWAIT;
            S_PWAIT: n_state = S_PMUL;
            S_PMUL:  n_state = S_PMUL2;
            S_PMUL2: n_state = S_PSAT;
            S_PSAT:  n_state = (r_t == TW'(MAX_TILINGS-1)) ?
                               (r_w.last_element ? S_LSET : S_IDLE) : S_PRD;
            S_LSET:  n_state = S_LRD;
            S_LRD:   n_state = S_LCMP;
            S_LCMP:  n_state = (hit && !scan_end) ? S_LEMIT :
                               (scan_end ? S_LEMIT : S_LRD);
            S_LEMIT: n_state = (r_t == r_n_last) ? S_IDLE : S_LRD;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_idle = (r_state == S_IDLE);
    assign st_we  = (r_state == S_LCMP) && scan_end && miss_ok;

    logic [3:0] nact;
    assign nact = (i_active == 4'd0) ? 4'd1 :
                  ((32'(i_active) > MAX_TILINGS) ? 4'(MAX_TILINGS) : i_active);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_pos   <= '0;
            r_next  <= '0;
            r_i     <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < MAX_TILINGS; k++) begin
                r_hash[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_t <= '0;
                    if (!i_empty && i_word.cmd == tcfa_pkg::CMD_SAMPLE) begin
                        r_n_last <= TW'(nact - 4'd1);
                    end
                end
                S_PSAT: begin
                    if (r_ena) begin
                        r_hash[r_t] <= (r_hash[r_t] << 5) - r_hash[r_t] + coord;
                    end
                    if (r_t == TW'(MAX_TILINGS-1)) begin
                        r_t   <= '0;
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_LSET: begin
                    r_t <= '0;
                    r_i <= '0;
                end
                S_LCMP: begin
                    r_i <= r_i + 1'b1;
                    if (hit && !scan_end) begin
                        o_feature_id    <= sf_rd;
                        o_newly_created <= 1'b0;
                        o_table_full    <= 1'b0;
                        o_feature_count <= r_next;
                    end else if (scan_end) begin
                        if (miss_ok) begin
                            o_feature_id    <= r_next[10:0];
                            o_newly_created <= 1'b1;
                            o_table_full    <= 1'b0;
                            o_feature_count <= r_next + 12'd1;
                            r_fill[r_t]     <= r_fill[r_t] + 1'b1;
                            r_next          <= r_next + 12'd1;
                        end else begin
                            o_feature_id    <= '0;
                            o_newly_created <= 1'b0;
                            o_table_full    <= 1'b1;
                            o_feature_count <= r_next;
                        end
                    end
                end
                S_LEMIT: begin
                    o_valid         <= 1'b1;
                    o_tiling_number <= 3'(r_t);
                    o_last_result   <= (r_t == r_n_last);
                    r_i             <= '0;
                    if (r_t == r_n_last) begin
                        r_t   <= '0;
                        r_pos <= '0;
                        for (int k = 0; k < MAX_TILINGS; k++) begin
                            r_hash[k] <= '0;
                        end
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers for the item and the multiply
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w <= i_word;
        end
        if (r_state == S_PWAIT) begin
            r_neg <= diff[32];
            r_mag <= dmag;
            r_ena <= en_rd;
            r_inv <= inv_rd;
        end
        if (r_state == S_PMUL) begin
            r_phi <= mpart;
        end
        if (r_state == S_PMUL2) begin
            r_prod <= 64'(r_phi) + {mpart, 16'd0};
        end
    end

endmodule

@@ rtl/core/tile_coding_feature_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tile_coding_feature_allocator_top
// Tile-coding feature extractor with per-tiling hash tables.
//
//   channel   handshake            payload
//   command   i_start / o_busy     i_command .. i_last_element
//   result    o_result_valid       o_tiling_number .. o_last_result
//   config    i_cfg_we             i_cfg_wdata (active_tilings)
//
// A word is registered in the queue before it reaches the engine. A load
// word writes the parameter memories. A sample word is quantised and hashed
// for every tiling in turn through the one shared multiplier (read, wait,
// two multiply halves, saturate). The last word then sets up the walk and,
// per active tiling, reads and compares stored entries until a hit or the
// end of the table, then emits a result. Reset is synchronous; the receiver
// cannot stall, and o_busy rises while the two-word queue is full.
// ----------------------------------------------------------------------------
module tile_coding_feature_allocator_top #(
    parameter int MAX_TILINGS   = tcfa_pkg::MAX_TILINGS_DEF,
    parameter int MAX_DIMS      = tcfa_pkg::MAX_DIMS_DEF,
    parameter int TABLE_ENTRIES = tcfa_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [2:0]  i_tiling_index,
    input  logic [3:0]  i_dim_index,
    input  logic        i_dim_enabled,
    input  logic [31:0] i_offset_value,
    input  logic [31:0] i_inverse_width,
    input  logic [31:0] i_sample_value,
    input  logic        i_last_element,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic [2:0]  o_tiling_number,
    output logic [10:0] o_feature_id,
    output logic        o_newly_created,
    output logic        o_table_full,
    output logic [11:0] o_feature_count,
    output logic        o_last_result
);

    logic [3:0]      r_active;
    tcfa_pkg::t_word in_word, q_word;
    logic            q_full, q_empty, q_pop, eng_idle;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= tcfa_pkg::ACT_RST;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign in_word = '{cmd: i_command, tiling_index: i_tiling_index,
                       dim_index: i_dim_index, dim_enabled: i_dim_enabled,
                       offset_value: i_offset_value, inverse_width: i_inverse_width,
                       sample_value: i_sample_value, last_element: i_last_element};
    assign o_busy = q_full;

    tcfa_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n, .i_push(i_start && !q_full), .i_word(in_word),
        .o_full(q_full), .o_empty(q_empty), .i_pop(q_pop), .o_word(q_word));

    tcfa_engine #(
        .MAX_TILINGS(MAX_TILINGS), .MAX_DIMS(MAX_DIMS), .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_engine (
        .i_clk, .i_rst_n, .i_active(r_active), .i_empty(q_empty), .i_word(q_word),
        .o_pop(q_pop), .o_idle(eng_idle), .o_valid(o_result_valid),
        .o_tiling_number, .o_feature_id, .o_newly_created, .o_table_full,
        .o_feature_count, .o_last_result);

`ifndef NO_ASSERTIONS
    // a result only appears while the engine has moved on to its next step
    a_no_pop_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !$past(q_pop)) else $error("result and pop overlap");
    // engine never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");
    // a fresh id never comes with the full flag
    a_new_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_newly_created && o_table_full)) else $error("new and full");
    // engine keeps walking tables until the last result of a vector
    a_busy_mid_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_result) |-> !eng_idle) else $error("idle mid vector");
`endif

endmodule
